@@ design/deq_pkg.sv @@
// Package for the double-ended queue: sizes, command and status codes,
// and the ring index helpers. No dependencies.
package deq_pkg;

	localparam int DEPTH      = 64;
	localparam int WORD_BITS  = 64;
	localparam int FIELD_BITS = 64;
	localparam int PTR_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int SUM_W      = CNT_W + 1;

	typedef logic [PTR_W-1:0]     ptr_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [WORD_BITS-1:0] word_t;

	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_PEEK_FRONT = 3'd4,
		CMD_PEEK_BACK  = 3'd5,
		CMD_CLEAR      = 3'd6,
		CMD_QUERY      = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_WORD  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// front + offset wrapped into the ring; the sum stays below twice the depth for an offset up to the depth
	function automatic ptr_t ring_add(input ptr_t base, input cnt_t offset);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(offset);
		if (sum >= SUM_W'(DEPTH)) begin
			sum = sum - SUM_W'(DEPTH);
		end
		return PTR_W'(sum);
	endfunction

	// one step back around the ring
	function automatic ptr_t ring_dec(input ptr_t base);
		if (base == '0) begin
			return PTR_W'(DEPTH - 1);
		end
		return base - PTR_W'(1);
	endfunction

endpackage

@@ design/deq_cmd_if.sv @@
// Command channel of the double-ended queue: valid/ready plus command payload.
// Depends on nothing.
interface deq_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic [63:0] word_in;

	modport source (output valid, output command, output word_in, input ready);
	modport sink   (input valid, input command, input word_in, output ready);
endinterface

@@ design/deq_res_if.sv @@
// Result channel of the double-ended queue: valid/ready plus result payload.
// Depends on nothing.
interface deq_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [63:0] word_out;
	logic        is_empty;

	modport source (output valid, output status, output word_out, output is_empty,
		input ready);
	modport sink   (input valid, input status, input word_out, input is_empty,
		output ready);
endinterface

@@ design/double_ended_queue.sv @@
// Double-ended queue of fixed-width words held in a ring buffer.
// Uses deq_pkg, deq_cmd_if, deq_res_if and deq_ram.
//
// Channels: cmd carries one command per transaction (push front/back,
// pop front/back, peek front/back, clear, query empty) with a word for
// pushes; res returns exactly one result transaction per command, in
// order: status, the popped or peeked word, and the empty flag.
// Latency: the result is valid in the cycle after the command is taken.
// Throughput: one command per cycle while res is taken each cycle. The
// end pointers and count update at the command edge, and the word store
// RAM takes one write or one registered read per command, so the next
// command may address the ring at once; a read lands in the RAM output
// register, which is the result's word.
// A push onto a full queue is dropped and reports full; a pop or peek of
// an empty queue reports empty.
// Reset: the queue is empty with both ends at entry 0; the store itself
// is not cleared, and no clearing pass is needed.
// Stall: while a result waits on res, cmd.ready is low and the RAM
// output register holds, so nothing is lost.
module double_ended_queue
	import deq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	deq_cmd_if.sink    cmd,
	deq_res_if.source  res
);

	ptr_t    front_q;
	cnt_t    count_q;
	logic    res_valid_s1;
	status_t status_s1;
	logic    is_empty_s1;

	ptr_t    front_nxt;
	cnt_t    count_nxt;
	status_t status_nxt;
	logic    ram_we;
	logic    ram_re;
	ptr_t    ram_waddr;
	ptr_t    ram_raddr;
	word_t   ram_rdata;
	logic    accept;
	logic    full;
	logic    empty;
	ptr_t    back_free;
	ptr_t    back_last;
	cmd_t    op;

	assign accept    = cmd.valid && cmd.ready;
	assign cmd.ready = !res_valid_s1 || res.ready;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign back_free = ring_add(front_q, count_q);
	assign back_last = ring_add(front_q, count_q - CNT_W'(1));
	assign op        = cmd_t'(cmd.command);

	// command decode: pointer update, RAM access and status
	always_comb begin
		front_nxt  = front_q;
		count_nxt  = count_q;
		status_nxt = ST_OK;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_waddr  = back_free;
		ram_raddr  = front_q;
		unique case (op) inside
			CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					ram_we    = accept;
					count_nxt = count_q + CNT_W'(1);
					if (op == CMD_PUSH_FRONT) begin
						front_nxt = ring_dec(front_q);
						ram_waddr = ring_dec(front_q);
					end
				end
			end
			CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					status_nxt = ST_WORD;
					ram_re     = accept;
					if (op == CMD_POP_BACK || op == CMD_PEEK_BACK) begin
						ram_raddr = back_last;
					end
					if (op == CMD_POP_FRONT || op == CMD_POP_BACK) begin
						count_nxt = count_q - CNT_W'(1);
						if (op == CMD_POP_FRONT) begin
							front_nxt = ring_add(front_q, CNT_W'(1));
						end
						// last word gone: both ends return to entry 0
						if (count_q == CNT_W'(1)) begin
							front_nxt = '0;
						end
					end
				end
			end
			CMD_CLEAR: begin
				front_nxt = '0;
				count_nxt = '0;
			end
			CMD_QUERY: begin
			end
			default: begin
			end
		endcase
	end

	deq_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (cmd.word_in[WORD_BITS-1:0]),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ring state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			front_q <= front_nxt;
			count_q <= count_nxt;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s1 <= 1'b0;
		end else if (accept) begin
			res_valid_s1 <= 1'b1;
		end else if (res.ready) begin
			res_valid_s1 <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1   <= status_nxt;
			is_empty_s1 <= (count_nxt == '0);
		end
	end

	assign res.valid    = res_valid_s1;
	assign res.status   = status_s1;
	assign res.word_out = (status_s1 == ST_WORD) ? FIELD_BITS'(ram_rdata) : '0;
	assign res.is_empty = is_empty_s1;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("word count beyond depth");

	a_empty_front: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> front_q == '0)
		else $error("front not at entry 0 while empty");

	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ram_re |=> res_valid_s1 && status_s1 == ST_WORD)
		else $error("store read without a word result");

	a_stall_block: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s1 && !res.ready |-> !cmd.ready)
		else $error("command taken while result stalled");
`endif

endmodule

@@ design/deq_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module deq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
